// ===== design/fractional_feedback_delay_line_assert.svh =====
// Assertion macros shared by the checker of the fractional feedback delay line.
`ifndef FRACTIONAL_FEEDBACK_DELAY_LINE_ASSERT_SVH
`define FRACTIONAL_FEEDBACK_DELAY_LINE_ASSERT_SVH

// Implication checked from the next cycle on, ignored while reset is held.
`define FFDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ffdl assertion failed");

// Same-cycle implication, ignored while reset is held.
`define FFDL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ffdl assertion failed");

// Next-cycle implication that also applies during reset.
`define FFDL_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ffdl assertion failed");

`endif

// ===== design/ffdl_pkg.sv =====
// Shared constants, types and state encoding of the fractional feedback delay line.
package ffdl_pkg;

    // The sample store depth must be a power of two.
    localparam int BUF_DEPTH  = 131072;
    localparam int BUF_AW     = $clog2(BUF_DEPTH);

    localparam int SAMPLE_W   = 24;
    localparam int DELAY_W    = 25;
    localparam int FRAC_W     = 8;
    localparam int DINT_W     = DELAY_W - FRAC_W;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 15;

    localparam int PROD_W     = SAMPLE_W + 1 + FRAC_W + 1;
    localparam int FB_W       = GAIN_W + SAMPLE_W;
    localparam int MIX_RND    = 1 << (FRAC_W - 1);
    localparam int FB_RND     = 1 << (GAIN_FRAC - 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DELAY_W;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP1,
        ST_TAP2,
        ST_MIX,
        ST_FBM,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_old;
        logic lat_newer;
        logic lat_prod;
        logic lat_y;
        logic lat_fb;
        logic wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic bypass;
        logic out_free;
    } t_sts;

endpackage

// ===== design/ffdl_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module ffdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ffdl_ctrl.sv =====
// Sequencing state machine of the fractional feedback delay line.
module ffdl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ffdl_pkg::t_sts i_sts,
    output ffdl_pkg::t_cmd o_cmd
);

    import ffdl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.bypass ? ST_DONE : ST_TAP1;
                end
            end
            ST_TAP1:  n_state = ST_TAP2;
            ST_TAP2:  n_state = ST_MIX;
            ST_MIX:   n_state = ST_FBM;
            ST_FBM:   n_state = ST_WRITE;
            ST_WRITE: n_state = i_sts.out_free ? ST_IDLE : ST_DONE;
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_TAP1: begin
                o_cmd.rd_old    = 1'b1;
                o_cmd.lat_newer = 1'b1;
            end
            ST_TAP2:  o_cmd.lat_prod = 1'b1;
            ST_MIX:   o_cmd.lat_y    = 1'b1;
            ST_FBM:   o_cmd.lat_fb   = 1'b1;
            ST_WRITE: begin
                o_cmd.wr       = 1'b1;
                o_cmd.load_out = i_sts.out_free;
            end
            ST_DONE:  o_cmd.load_out = i_sts.out_free;
            default: begin
                o_cmd   = '0;
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/ffdl_dp.sv =====
// Datapath: configuration, sample store, interpolation, feedback and output register.
module ffdl_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ffdl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [ffdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic signed [ffdl_pkg::SAMPLE_W-1:0] o_sample_out,
    input  ffdl_pkg::t_cmd                        i_cmd,
    output ffdl_pkg::t_sts                        o_sts
);

    import ffdl_pkg::*;

    logic [DELAY_W-1:0]         r_delay;
    logic signed [GAIN_W-1:0]   r_gain;
    logic [BUF_AW-1:0]          r_wp;
    logic                       r_full;
    logic                       r_rd_valid;
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_newer;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [FB_W-1:0]     r_fb;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_out_valid;

    logic [DINT_W-1:0]          w_dint;
    logic [FRAC_W-1:0]          w_frac;
    logic [BUF_AW-1:0]          w_rd_new;
    logic [BUF_AW-1:0]          w_rd_old;
    logic [BUF_AW-1:0]          w_raddr;
    logic [SAMPLE_W-1:0]        w_rdata;
    logic signed [SAMPLE_W-1:0] w_tap;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_mix;
    logic signed [PROD_W-1:0]   w_mix_sh;
    logic signed [SAMPLE_W-1:0] w_y;
    logic signed [FB_W-1:0]     w_fbr;
    logic signed [FB_W-1:0]     w_fbs;
    logic signed [SAMPLE_W+1:0] w_st;
    logic signed [SAMPLE_W-1:0] w_wdata;
    logic                       w_out_free;

    assign w_dint   = r_delay[DELAY_W-1:FRAC_W];
    assign w_frac   = r_delay[FRAC_W-1:0];
    assign w_rd_new = r_wp - BUF_AW'(w_dint);
    assign w_rd_old = w_rd_new - BUF_AW'(1);
    assign w_raddr  = i_cmd.rd_old ? w_rd_old : w_rd_new;

    ffdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BUF_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_wp),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Entries are written in address order from zero, so an address at or above the
    // write pointer has not been written since reset until the pointer first wraps.
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_full || (w_raddr < r_wp);
    end

    assign w_tap = r_rd_valid ? $signed(w_rdata) : '0;

    // newer*(256-f) + older*f equals newer*256 + (older-newer)*f.
    assign w_diff   = {w_tap[SAMPLE_W-1], w_tap} - {r_newer[SAMPLE_W-1], r_newer};
    assign w_prod   = w_diff * $signed({1'b0, w_frac});
    assign w_mix    = r_prod + PROD_W'(MIX_RND);
    assign w_mix_sh = w_mix >>> FRAC_W;
    assign w_y      = r_newer + SAMPLE_W'(w_mix_sh);

    assign w_fbr    = r_fb + FB_W'(FB_RND);
    assign w_fbs    = w_fbr >>> GAIN_FRAC;
    assign w_st     = {{2{r_x[SAMPLE_W-1]}}, r_x} + (SAMPLE_W + 2)'(w_fbs);

    always_comb begin
        if (w_st[SAMPLE_W+1:SAMPLE_W-1] == 3'b000 || w_st[SAMPLE_W+1:SAMPLE_W-1] == 3'b111) begin
            w_wdata = w_st[SAMPLE_W-1:0];
        end else if (w_st[SAMPLE_W+1]) begin
            w_wdata = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            w_wdata = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
            r_gain  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY: r_delay <= i_cfg_data;
                CFG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                default:   r_delay <= r_delay;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_cmd.wr) begin
            if (r_wp == BUF_AW'(BUF_DEPTH - 1)) begin
                r_wp   <= '0;
                r_full <= 1'b1;
            end else begin
                r_wp <= r_wp + BUF_AW'(1);
            end
        end
    end

    // A bypassed transaction leaves the input in r_y as its result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x <= i_sample_in;
            r_y <= i_sample_in;
        end else if (i_cmd.lat_y) begin
            r_y <= w_y;
        end
        if (i_cmd.lat_newer) begin
            r_newer <= (w_dint == '0) ? r_x : w_tap;
        end
        if (i_cmd.lat_prod) begin
            r_prod <= w_prod;
        end
        if (i_cmd.lat_fb) begin
            r_fb <= r_gain * r_y;
        end
        if (i_cmd.load_out) begin
            r_out <= r_y;
        end
    end

    assign w_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.bypass   = (r_delay == '0);
    assign o_sts.out_free = w_out_free;
    assign o_valid        = r_out_valid;
    assign o_sample_out   = r_out;

endmodule

// ===== design/fractional_feedback_delay_line.sv =====
// Top level of the fractional feedback delay line.
// One 24-bit sample goes in and one delayed sample comes out per transaction. With a
// nonzero delay a transaction steps through the states IDLE, where it is accepted,
// TAP1, TAP2, MIX, FBM and WRITE, and its result reaches the output register at the
// end of WRITE if that register is free, raising o_valid. The taps are read one
// after the other through the single read port of the 131072-entry sample store,
// then registered steps follow for the interpolation multiply, the rounding sum and
// the feedback multiply, and a last step saturates and writes back the feedback sum.
// With a delay of exactly zero the sample passes straight to the output register and
// the store is untouched. A finished result waits in the output register; the next
// transaction is taken once the block has moved the previous result there, so a
// receiver stall while a new result is ready delays the next transaction. The store
// needs no clearing pass after reset: entries not yet written since reset read as
// zero, tracked by the write pointer.
module fractional_feedback_delay_line (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ffdl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ffdl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [ffdl_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [ffdl_pkg::SAMPLE_W-1:0] o_sample_out
);

    import ffdl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ffdl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ffdl_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

endmodule

// ===== design/ffdl_checker.sv =====
// Port-level checker of the fractional feedback delay line and its bind.
`include "fractional_feedback_delay_line_assert.svh"

module ffdl_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_ready,
    input logic                                 o_valid,
    input logic                                 i_ready,
    input logic signed [ffdl_pkg::SAMPLE_W-1:0] o_sample_out
);

    // Reset empties the output register.
    `FFDL_ASSERT_RST(a_reset_empty, !i_rst_n, !o_valid)

    // A stalled result keeps its value.
    `FFDL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_sample_out))

    // One transaction at a time: the block is busy right after taking one.
    `FFDL_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)

    // A new result is only produced while a transaction is in flight.
    `FFDL_ASSERT_NOW(a_result_from_work, $rose(o_valid), !$past(o_ready))

endmodule

bind fractional_feedback_delay_line ffdl_checker u_ffdl_checker (.*);
